>>> rtl/tar_pkg.sv
package tar_pkg;

  // sample in 1/8 degree steps, result in whole degrees
  typedef logic signed [15:0] sample_t;
  typedef logic signed [13:0] degrees_t;
  typedef logic [7:0]         warmup_t;

  localparam warmup_t    WARMUP_RESET = 8'd10;
  localparam int         FRAC_BITS    = 3;
  localparam logic [2:0] FRAC_MASK    = 3'h7;
  localparam logic [2:0] HALF_STEP    = 3'h4;

endpackage

>>> rtl/tar_ring.sv
module tar_ring #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [AW-1:0]    addr,
  input  tar_pkg::sample_t wdata,
  output tar_pkg::sample_t rdata
);
  import tar_pkg::*;

  sample_t          mem [DEPTH];
  logic [DEPTH-1:0] filled;
  sample_t          rd_q;
  logic             rd_filled;

  // read-first: same-address read returns the entry being replaced
  always_ff @(posedge clk) begin
    if (en) begin
      rd_q          <= mem[addr];
      mem[addr]     <= wdata;
    end
  end

  // per-entry fill flags stand in for the cleared-at-reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else if (en) begin
      rd_filled    <= filled[addr];
      filled[addr] <= 1'b1;
    end
  end

  assign rdata = rd_filled ? rd_q : sample_t'(0);

endmodule

>>> rtl/tar_out_queue.sv
module tar_out_queue #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tar_pkg::degrees_t push_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tar_pkg::degrees_t out_data
);
  import tar_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  degrees_t        entry [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            pop;

  assign out_valid = (count != '0);
  assign out_data  = entry[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/temperature_average_and_round.sv
// Beat path: ring read, running total, magnitude, multiply, select, output queue.
// Throughput: one beat per cycle while in_stall is low; ring RAM read-first, once per beat.
// Up to 8 beats may be in flight; in_stall rises only when the output queue backs up.
// Reset (rst, synchronous): ring reads as zero, total, slot and warm-up count cleared,
// warmup_samples back to 10, pipeline and output queue emptied.
module temperature_average_and_round #(
  parameter int AVG_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  tar_pkg::warmup_t  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  tar_pkg::sample_t  sample_eighths,
  output logic              out_valid,
  input  logic              out_stall,
  output tar_pkg::degrees_t degrees_rounded
);
  import tar_pkg::*;

  localparam int LOG = $clog2(AVG_DEPTH);
  localparam int AW  = (LOG > 0) ? LOG : 1;
  // running total of AVG_DEPTH 16-bit samples
  localparam int TW  = 16 + LOG;
  // reciprocal: floor(x / N) == (x * ceil(2^S / N)) >> S for every x < 2^TW
  localparam int S   = TW + LOG;
  localparam int MW  = S + 1;
  localparam longint MULT = ((longint'(1) << S) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam logic [MW-1:0] MULT_V = MW'(MULT);
  localparam int PW  = TW + MW;
  // credit window: pipeline stages plus output queue
  localparam int QDEPTH = 8;
  localparam int CW  = $clog2(QDEPTH + 1);

  // ---------------------------------------------------------------------------
  // Handshake and credits. Every beat in the pipe has a queue slot waiting,
  // so the pipe never stalls internally.
  // ---------------------------------------------------------------------------
  logic          accept;
  logic          take;
  logic [CW-1:0] in_flight;

  assign in_stall = (in_flight == CW'(QDEPTH));
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      case ({accept, take})
        2'b10:   in_flight <= in_flight + 1'b1;
        2'b01:   in_flight <= in_flight - 1'b1;
        default: in_flight <= in_flight;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and warm-up tracking. Warm-up decision is made at accept.
  // ---------------------------------------------------------------------------
  warmup_t warmup_samples;
  warmup_t warmup_seen;
  logic    pass_raw;

  assign pass_raw = (warmup_seen < warmup_samples);

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_samples <= WARMUP_RESET;
    end else if (cfg_wr_en) begin
      warmup_samples <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_seen <= '0;
    end else if (accept && pass_raw) begin
      warmup_seen <= warmup_seen + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: ring RAM access at the write slot. The new sample replaces the
  // oldest one and the old value comes back in the following cycle.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] write_slot;
  sample_t       ring_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (accept) begin
      write_slot <= (write_slot == AW'(AVG_DEPTH - 1)) ? '0 : write_slot + 1'b1;
    end
  end

  tar_ring #(
    .DEPTH (AVG_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .en    (accept),
    .addr  (write_slot),
    .wdata (sample_eighths),
    .rdata (ring_old)
  );

  logic    v1, v2, v3, v4, v5;
  sample_t smp1, smp2, smp3, smp4;
  logic    pass1, pass2, pass3, pass4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    smp1  <= sample_eighths;
    pass1 <= pass_raw;
    smp2  <= smp1;
    pass2 <= pass1;
    smp3  <= smp2;
    pass3 <= pass2;
    smp4  <= smp3;
    pass4 <= pass3;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: running total update (drop oldest, add newest).
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] running_total;
  logic signed [TW-1:0] old_ext;
  logic signed [TW-1:0] new_ext;

  assign old_ext = TW'(ring_old);
  assign new_ext = TW'(smp1);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
    end else if (v1) begin
      running_total <= running_total - old_ext + new_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sign and magnitude, so the divide truncates toward zero.
  // Most negative total negates to its own bit pattern, the right magnitude.
  // ---------------------------------------------------------------------------
  logic [TW-1:0] mag3;
  logic          neg3;

  always_ff @(posedge clk) begin
    neg3 <= running_total[TW-1];
    mag3 <= running_total[TW-1] ? TW'(-running_total) : TW'(running_total);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: reciprocal multiply for the divide by AVG_DEPTH.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] prod4;
  logic          neg4;

  always_ff @(posedge clk) begin
    neg4  <= neg3;
    prod4 <= PW'(mag3) * PW'(MULT_V);
  end

  // ---------------------------------------------------------------------------
  // Stage 4: restore sign, pick raw sample during warm-up.
  // ---------------------------------------------------------------------------
  logic [15:0]        quot;
  logic signed [16:0] mean17;
  sample_t            chosen5;

  assign quot   = prod4[S +: 16];
  assign mean17 = neg4 ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk) begin
    chosen5 <= pass4 ? smp4 : sample_t'(mean17[15:0]);
  end

  // ---------------------------------------------------------------------------
  // Stage 5: round to whole degrees (floor shift, up when fraction >= half).
  // ---------------------------------------------------------------------------
  logic signed [12:0] whole;
  logic [2:0]         frac;
  logic               round_up;
  degrees_t           rounded;

  assign whole    = chosen5[15:FRAC_BITS];
  assign frac     = chosen5[2:0] & FRAC_MASK;
  assign round_up = (frac >= HALF_STEP);
  assign rounded  = degrees_t'(whole) + degrees_t'({13'b0, round_up});

  tar_out_queue #(
    .DEPTH (QDEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (v5),
    .push_data (rounded),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (degrees_rounded)
  );

endmodule
